### rtl/core/cemf_pkg.sv
// Shared definitions for the contour extreme and midpoint finder.
// Holds the configuration register indexes, default sizes and the
// command and status words between the controller and the datapath.
`default_nettype none

package cemf_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_COORD_BITS = 12;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTRAINT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HEIGHT       = 2'd2;

  // Starting best column distance of the nearest-point search.
  localparam int NO_MATCH_DIST = 1000;
  localparam int NO_MATCH_BITS = 10;

  // Column window of the partner-row search.
  localparam int NEAR_COLS = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // a point word is accepted this cycle
    logic scan_rd;    // read the next stored point
    logic scan_pass2; // the read belongs to the partner-row pass
    logic result_ld;  // load the result register, end the set
  } cemf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the read index points at the last stored point
  } cemf_stat_t;

endpackage

`default_nettype wire

### rtl/core/cemf_ctrl.sv
// Controller of the contour extreme and midpoint finder.
// Sequences loading, the two scans over the point store and the result
// handoff. Depends on cemf_pkg.
`default_nettype none

module cemf_ctrl
  import cemf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_is_last,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output cemf_cmd_t       cmd,
  input  wire cemf_stat_t stat
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_P1,
    S_P1_END,
    S_P2,
    S_P2_END,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   res_free;

  assign in_stall  = (state_r != S_LOAD);
  assign accept    = in_valid && (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  // The result register can take a new word when it is empty or being drained.
  assign res_free  = !out_valid_r || !out_stall;

  // Commands decoded from the state.
  always_comb begin
    cmd            = '0;
    cmd.store      = accept;
    cmd.scan_rd    = (state_r == S_P1) || (state_r == S_P2);
    cmd.scan_pass2 = (state_r == S_P2);
    cmd.result_ld  = (state_r == S_FINISH) && res_free;
  end

  // Next-state logic.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_LOAD: begin
        if (accept && in_is_last) begin
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        if (stat.scan_last) begin
          state_nxt = S_P1_END;
        end
      end
      S_P1_END: begin
        state_nxt = S_P2;
      end
      S_P2: begin
        if (stat.scan_last) begin
          state_nxt = S_P2_END;
        end
      end
      S_P2_END: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (res_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State and registered output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cemf_dp.sv
// Datapath of the contour extreme and midpoint finder.
// Holds the configuration registers, the point store, the extreme tracking,
// the two scan compare units and the result register. Depends on cemf_pkg.
`default_nettype none

module cemf_dp
  import cemf_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  input  wire logic [COORD_BITS-1:0] in_point_x,
  input  wire logic [COORD_BITS-1:0] in_point_y,
  input  wire cemf_cmd_t             cmd,
  output cemf_stat_t                 stat,
  output logic [COORD_BITS-1:0]      out_left_x,
  output logic [COORD_BITS-1:0]      out_left_y,
  output logic [COORD_BITS-1:0]      out_right_x,
  output logic [COORD_BITS-1:0]      out_right_y,
  output logic [COORD_BITS-1:0]      out_middle_x,
  output logic [COORD_BITS-1:0]      out_upper_y,
  output logic [COORD_BITS-1:0]      out_lower_y
);

  localparam int CW     = COORD_BITS;
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIST_W = (CW > NO_MATCH_BITS) ? CW : NO_MATCH_BITS;
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_POINTS);
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(NO_MATCH_DIST);
  localparam logic [CW-1:0]     NEAR_LIM   = CW'(NEAR_COLS);

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers.
  logic          cons_en_r;
  logic [CW-1:0] center_y_r;
  logic [CW-1:0] band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cons_en_r  <= 1'b0;
      center_y_r <= '0;
      band_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CONSTRAINT_ENABLE: cons_en_r  <= cfg_data[0];
        CFG_CENTER_Y:          center_y_r <= cfg_data;
        CFG_BAND_HEIGHT:       band_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Point store, one word of x and y per entry.
  logic [2*CW-1:0] mem [MAX_POINTS];
  logic [2*CW-1:0] rdata_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              vld_r, pass2_r;
  logic              not_full;
  logic              do_store;

  assign not_full = (cnt_r != CNT_FULL);
  assign do_store = cmd.store && not_full;

  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[cnt_r[ADDR_W-1:0]] <= {in_point_x, in_point_y};
    end
    if (cmd.scan_rd) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  // Point count and scan read index.
  assign stat.scan_last = (CNT_W'(rd_idx_r) == CNT_W'(cnt_r - 1'b1));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.result_ld) begin
      cnt_nxt = '0;
    end else if (do_store) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    rd_idx_nxt = rd_idx_r;
    if (cmd.scan_rd) begin
      rd_idx_nxt = stat.scan_last ? '0 : ADDR_W'(rd_idx_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_idx_r <= '0;
      vld_r    <= 1'b0;
      pass2_r  <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
      vld_r    <= cmd.scan_rd;
      pass2_r  <= cmd.scan_pass2;
    end
  end

  // Extreme tracking while loading; point 0 always seeds the extremes.
  logic [CW-1:0] lx_r, ly_r, rx_r, ry_r;
  logic          qualify;

  assign qualify = !cons_en_r || (abs_diff(in_point_y, center_y_r) <= band_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r <= '0;
      ly_r <= '0;
      rx_r <= '0;
      ry_r <= '0;
    end else if (do_store) begin
      if (cnt_r == '0) begin
        lx_r <= in_point_x;
        ly_r <= in_point_y;
        rx_r <= in_point_x;
        ry_r <= in_point_y;
      end else if (qualify) begin
        if (in_point_x > rx_r) begin
          rx_r <= in_point_x;
          ry_r <= in_point_y;
        end
        if (in_point_x < lx_r) begin
          lx_r <= in_point_x;
          ly_r <= in_point_y;
        end
      end
    end
  end

  // Midpoint of the extremes, stable during the scans.
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;

  assign mid_sum = {1'b0, lx_r} + {1'b0, rx_r};
  assign mid     = mid_sum[CW:1];

  // Scan compare units. Point 0 sets the defaults of both searches.
  logic [DIST_W-1:0] best_r;
  logic [CW-1:0]     chosen_x_r, chosen_y_r;
  logic [CW-1:0]     large_r, partner_r;
  logic [CW-1:0]     rd_x, rd_y;
  logic [CW-1:0]     d_mid, d_col, d_row;
  logic              near;

  assign rd_x  = rdata_r[2*CW-1:CW];
  assign rd_y  = rdata_r[CW-1:0];
  assign d_mid = abs_diff(mid, rd_x);
  assign d_col = abs_diff(chosen_x_r, rd_x);
  assign d_row = abs_diff(rd_y, chosen_y_r);
  assign near  = (d_col <= NEAR_LIM) && (rd_y != chosen_y_r);

  always_ff @(posedge clk) begin
    if (do_store && (cnt_r == '0)) begin
      best_r     <= DIST_START;
      chosen_x_r <= in_point_x;
      chosen_y_r <= in_point_y;
      large_r    <= '0;
      partner_r  <= in_point_y;
    end else if (vld_r && !pass2_r) begin
      // First pass: first point nearest to the midpoint column.
      if (DIST_W'(d_mid) < best_r) begin
        best_r     <= DIST_W'(d_mid);
        chosen_x_r <= rd_x;
        chosen_y_r <= rd_y;
      end
    end else if (vld_r && pass2_r) begin
      // Second pass: first neighbor row farthest from the chosen row.
      if (near && (d_row > large_r)) begin
        large_r   <= d_row;
        partner_r <= rd_y;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.result_ld) begin
      out_left_x   <= lx_r;
      out_left_y   <= ly_r;
      out_right_x  <= rx_r;
      out_right_y  <= ry_r;
      out_middle_x <= chosen_x_r;
      out_upper_y  <= (chosen_y_r > partner_r) ? partner_r : chosen_y_r;
      out_lower_y  <= (chosen_y_r > partner_r) ? chosen_y_r : partner_r;
    end
  end

endmodule

`default_nettype wire

### rtl/core/contour_extreme_midpoint_finder.sv
// Top level of the contour extreme and midpoint finder.
// Joins the controller and the datapath. Depends on cemf_pkg, cemf_ctrl
// and cemf_dp.
//
// Usage: contour points arrive one word per cycle on the in_ channel while
// in_stall is low, the final point of a contour flagged by in_is_last. Each
// point is stored, while the store has room, and folded into the leftmost
// and rightmost tracking in the cycle it is taken. After the last point the
// block stalls its input and makes two scans over the n stored points
// through the single read port of the point store, each with a registered
// read, then loads the result register. One result word appears on the out_
// channel per contour; the input reopens as soon as the word sits in the
// output register, so loading of the next contour overlaps a stalled
// receiver. If the receiver still stalls the old word when the next contour
// is done, the block waits with its input stalled. Configuration words on
// the cfg_ channel are always taken (cfg_ready is tied high) and belong
// between contours. Reset (rst_n low, synchronous) clears the point count,
// the extremes and the configuration.
`default_nettype none

module contour_extreme_midpoint_finder
  import cemf_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_point_x,
  input  wire logic [COORD_BITS-1:0] in_point_y,
  input  wire logic                  in_is_last,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      out_left_x,
  output logic [COORD_BITS-1:0]      out_left_y,
  output logic [COORD_BITS-1:0]      out_right_x,
  output logic [COORD_BITS-1:0]      out_right_y,
  output logic [COORD_BITS-1:0]      out_middle_x,
  output logic [COORD_BITS-1:0]      out_upper_y,
  output logic [COORD_BITS-1:0]      out_lower_y
);

  cemf_cmd_t  cmd;
  cemf_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencing of load, scans and result handoff.
  cemf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Storage, tracking and compare units.
  cemf_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .cmd          (cmd),
    .stat         (stat),
    .out_left_x   (out_left_x),
    .out_left_y   (out_left_y),
    .out_right_x  (out_right_x),
    .out_right_y  (out_right_y),
    .out_middle_x (out_middle_x),
    .out_upper_y  (out_upper_y),
    .out_lower_y  (out_lower_y)
  );

endmodule

`default_nettype wire

### tb/contour_result_checker.sv
`timescale 1ns / 100ps
// Checker for the contour extreme and midpoint finder: watches the config,
// point and result channels, predicts each result word and compares it.
// Depends on cemf_pkg.

module contour_result_checker
  import cemf_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_point_x,
  input  logic [COORD_BITS-1:0] in_point_y,
  input  logic                  in_is_last,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COORD_BITS-1:0] out_left_x,
  input  logic [COORD_BITS-1:0] out_left_y,
  input  logic [COORD_BITS-1:0] out_right_x,
  input  logic [COORD_BITS-1:0] out_right_y,
  input  logic [COORD_BITS-1:0] out_middle_x,
  input  logic [COORD_BITS-1:0] out_upper_y,
  input  logic [COORD_BITS-1:0] out_lower_y,
  output int                    mismatch_count,
  output int                    results_pending,
  output int                    results_checked
);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left_x;
    coord_t left_y;
    coord_t right_x;
    coord_t right_y;
    coord_t middle_x;
    coord_t upper_y;
    coord_t lower_y;
  } contour_word_t;

  // Our own copy of the point store, the extremes and the band registers.
  coord_t        held_x [MAX_POINTS];
  coord_t        held_y [MAX_POINTS];
  int unsigned   held_count;
  coord_t        leftmost_x, leftmost_y, rightmost_x, rightmost_y;
  logic          band_enable;
  coord_t        band_center, band_limit;
  contour_word_t expected_words [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
    results_checked = 0;
  end

  function automatic coord_t coord_dist(coord_t a, coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Works out the result word of the contour held so far: the extremes, the
  // stored point nearest their midpoint and the partner row around it.
  function automatic contour_word_t predict_contour_word();
    contour_word_t word;
    coord_t        mid, row, partner_row;
    int unsigned   best, pick, widest, partner, i;
    mid  = coord_t'(({1'b0, leftmost_x} + {1'b0, rightmost_x}) >> 1);
    best = NO_MATCH_DIST;
    pick = 0;
    for (i = 0; i < held_count; i++) begin
      if (coord_dist(mid, held_x[i]) < best) begin
        best = coord_dist(mid, held_x[i]);
        pick = i;
      end
    end
    mid     = held_x[pick];
    row     = held_y[pick];
    widest  = 0;
    partner = 0;
    for (i = 0; i < held_count; i++) begin
      if (coord_dist(mid, held_x[i]) <= NEAR_COLS && held_y[i] != row &&
          coord_dist(held_y[i], row) > widest) begin
        widest  = coord_dist(held_y[i], row);
        partner = i;
      end
    end
    // Without a partner the row of point 0 stands in.
    partner_row   = held_y[partner];
    word.left_x   = leftmost_x;
    word.left_y   = leftmost_y;
    word.right_x  = rightmost_x;
    word.right_y  = rightmost_y;
    word.middle_x = mid;
    word.upper_y  = (row > partner_row) ? partner_row : row;
    word.lower_y  = (row > partner_row) ? row : partner_row;
    return word;
  endfunction

  function automatic void check_field(string name, coord_t want, coord_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    contour_word_t want;
    if (!rst_n) begin
      held_count  = 0;
      leftmost_x  = '0;
      leftmost_y  = '0;
      rightmost_x = '0;
      rightmost_y = '0;
      band_enable = 1'b0;
      band_center = '0;
      band_limit  = '0;
      expected_words.delete();
    end else begin
      // A result word always belongs to an earlier contour, so it is matched
      // before a last point taken at the same edge adds a new expectation.
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with no contour pending: left_x %0d right_x %0d middle_x %0d",
                 out_left_x, out_right_x, out_middle_x);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("left_x", want.left_x, out_left_x);
          check_field("left_y", want.left_y, out_left_y);
          check_field("right_x", want.right_x, out_right_x);
          check_field("right_y", want.right_y, out_right_y);
          check_field("middle_x", want.middle_x, out_middle_x);
          check_field("upper_y", want.upper_y, out_upper_y);
          check_field("lower_y", want.lower_y, out_lower_y);
          results_checked++;
        end
      end

      // Register writes; the unused index is ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONSTRAINT_ENABLE: band_enable = cfg_data[0];
          CFG_CENTER_Y:          band_center = cfg_data;
          CFG_BAND_HEIGHT:       band_limit  = cfg_data;
          default: ;
        endcase
      end

      // Store the point and fold it into the extremes; a full store drops it.
      if (in_valid && !in_stall) begin
        if (held_count < MAX_POINTS) begin
          held_x[held_count] = in_point_x;
          held_y[held_count] = in_point_y;
          if (held_count == 0) begin
            leftmost_x  = in_point_x;
            leftmost_y  = in_point_y;
            rightmost_x = in_point_x;
            rightmost_y = in_point_y;
          end else if (!band_enable ||
                       coord_dist(in_point_y, band_center) <= band_limit) begin
            if (in_point_x > rightmost_x) begin
              rightmost_x = in_point_x;
              rightmost_y = in_point_y;
            end
            if (in_point_x < leftmost_x) begin
              leftmost_x = in_point_x;
              leftmost_y = in_point_y;
            end
          end
          held_count++;
        end
        if (in_is_last) begin
          expected_words.push_back(predict_contour_word());
          held_count = 0;
        end
      end
    end
    results_pending = expected_words.size();
  end

endmodule

### tb/tb_contour_extreme_midpoint_finder.sv
`timescale 1ns / 100ps
// Testbench top for the contour extreme and midpoint finder: drives point
// and configuration words, stalls the result channel and gives the verdict.
// Depends on cemf_pkg, the block and contour_result_checker.

module tb_contour_extreme_midpoint_finder;
  import cemf_pkg::*;

  localparam int MAX_POINTS    = DEF_MAX_POINTS;
  localparam int COORD_BITS    = DEF_COORD_BITS;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_POINTS  = 60;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 600000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;
  typedef enum {SHAPE_UNIFORM, SHAPE_CLUSTER, SHAPE_BORDER, SHAPE_COLUMNS} contour_shape_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COORD_BITS-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_BITS-1:0] in_point_x;
  logic [COORD_BITS-1:0] in_point_y;
  logic                  in_is_last;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_BITS-1:0] out_left_x;
  logic [COORD_BITS-1:0] out_left_y;
  logic [COORD_BITS-1:0] out_right_x;
  logic [COORD_BITS-1:0] out_right_y;
  logic [COORD_BITS-1:0] out_middle_x;
  logic [COORD_BITS-1:0] out_upper_y;
  logic [COORD_BITS-1:0] out_lower_y;

  int     mismatch_count, results_pending, results_checked;
  logic   hold_req;
  int     points_sent, contours_sent, settings_used, cycle_count;
  coord_t cur_center, cur_band;
  bit     pacing_on;
  int     burst_left, gap_max;

  contour_extreme_midpoint_finder #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) i_dut (.*);

  contour_result_checker #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) i_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result receiver: a stall pattern whose mode is redrawn at random, plus
  // one long hold-off on request so that the block backs up into its input.
  initial begin
    int          hold_left, tick;
    bit          hold_served;
    stall_mode_t mode;
    hold_left   = 0;
    hold_served = 0;
    tick        = 0;
    mode        = STALL_NONE;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 97 == 0) mode = stall_mode_t'($urandom_range(0, 3));
      if (hold_req && !hold_served) begin
        hold_served = 1;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
          STALL_PERIODIC: out_stall <= (tick % 8 < 3);
          default:        out_stall <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // Offers one point word and waits until the block takes it.
  task automatic send_point(coord_t x, coord_t y, bit last);
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    points_sent++;
    if (last) contours_sent++;
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace();
    int gap;
    if (pacing_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Waits until every expected word has come and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all three registers; the enable word carries random upper bits.
  task automatic configure(bit en, coord_t center, coord_t band, bit poke_unused);
    coord_t en_word;
    en_word    = coord_t'($urandom);
    en_word[0] = en;
    write_reg(CFG_CONSTRAINT_ENABLE, en_word);
    write_reg(CFG_CENTER_Y, center);
    write_reg(CFG_BAND_HEIGHT, band);
    if (poke_unused) write_reg(CFG_UNUSED_IDX, coord_t'($urandom));
    cfg_valid <= 1'b0;
    cur_center = center;
    cur_band   = band;
    settings_used++;
  endtask

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic coord_t border_coord();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return coord_t'(1);
      2:       return coord_t'(COORD_MAX - 1);
      3:       return coord_t'(COORD_MAX);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // One contour of random content. Clusters and narrow columns make the
  // partner search and the band test do real work.
  task automatic send_random_contour(int npts, contour_shape_t shape);
    int     base_x, spread, i;
    coord_t x, y;
    base_x = $urandom_range(0, COORD_MAX);
    spread = int'(cur_band) + 16;
    for (i = 0; i < npts; i++) begin
      case (shape)
        SHAPE_UNIFORM: begin
          x = coord_t'($urandom);
          y = coord_t'($urandom);
        end
        SHAPE_CLUSTER: begin
          x = clamp_coord(base_x + int'($urandom_range(0, 8)) - 4);
          y = clamp_coord(int'(cur_center) + int'($urandom_range(0, 2 * spread)) - spread);
        end
        SHAPE_BORDER: begin
          x = border_coord();
          y = border_coord();
        end
        default: begin
          x = clamp_coord(base_x + i % 3);
          y = clamp_coord(int'(cur_center) + int'($urandom_range(0, 64)) - 32);
        end
      endcase
      pace();
      send_point(x, y, i == npts - 1);
    end
  endtask

  initial begin
    int ph, phase_end, npts;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_is_last <= 1'b0;
    hold_req   <= 1'b0;
    points_sent   = 0;
    contours_sent = 0;
    settings_used = 0;
    pacing_on     = 0;
    burst_left    = 0;
    gap_max       = 12;
    cur_center    = '0;
    cur_band      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed contours, band constraint off.
    configure(0, '0, '0, 0);
    // Single-point contours at both corners.
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), 1);
    send_point('0, '0, 1);
    // Extremes too far apart: no column lies closer than 1000 to the midpoint.
    send_point('0, 100, 0);
    send_point(coord_t'(COORD_MAX), 200, 1);
    // Equal column distances keep the first point; partner in the same column.
    send_point(100, 10, 0);
    send_point(100, 20, 0);
    send_point(50, 5, 0);
    send_point(150, 30, 0);
    send_point(150, 31, 1);
    // Equal partner distances on both sides and a tie on the left extreme.
    send_point(500, 500, 0);
    send_point(501, 510, 0);
    send_point(499, 490, 0);
    send_point(400, 9, 0);
    send_point(400, 0, 0);
    send_point(600, 0, 1);
    // No partner column: the row of point 0 stands in.
    send_point('0, 3, 0);
    send_point(2000, 50, 0);
    send_point(2003, 60, 1);
    // All rows equal.
    send_point(10, 7, 0);
    send_point(12, 7, 1);
    drain();

    // Band constraint, including a first point outside the band.
    configure(1, 2048, '0, 0);
    send_point(1000, 100, 0);
    send_point(500, 2048, 0);
    send_point('0, 2047, 0);
    send_point(3000, 2048, 1);
    drain();
    configure(1, '0, coord_t'(COORD_MAX), 1);
    send_point(7, coord_t'(COORD_MAX), 0);
    send_point(coord_t'(COORD_MAX), '0, 1);
    drain();
    configure(1, coord_t'(COORD_MAX), '0, 0);
    send_point(5, coord_t'(COORD_MAX), 0);
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX - 1), 1);
    drain();

    // Random phases, each under its own register setting.
    ph = 0;
    while (ph < RANDOM_PHASES) begin
      case (ph % 6)
        0:       configure(0, coord_t'($urandom), coord_t'($urandom), 0);
        1:       configure(1, coord_t'($urandom), coord_t'($urandom_range(0, 300)), 0);
        2:       configure(1, '0, '0, 0);
        3:       configure(1, coord_t'(COORD_MAX), coord_t'(COORD_MAX), 0);
        4:       configure(1, coord_t'($urandom), '0, 1);
        default: configure(1, coord_t'($urandom), coord_t'($urandom), 0);
      endcase
      pacing_on = (ph % 3 != 0);
      gap_max   = (ph % 2 == 1) ? 4 : 12;
      if (ph == 1) hold_req <= 1'b1;
      phase_end = points_sent + PHASE_POINTS;
      while (points_sent < phase_end) begin
        npts = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        send_random_contour(npts, contour_shape_t'($urandom_range(0, 3)));
      end
      // Full store: one contour that fills the store and whose tail is
      // dropped, with the last flag on a dropped point.
      if (ph == 3) begin
        pacing_on = 0;
        send_random_contour(MAX_POINTS + $urandom_range(1, 4), SHAPE_UNIFORM);
      end
      drain();
      ph++;
    end

    $display("Checked %0d result words from %0d contours, %0d points, under %0d settings.",
             results_checked, contours_sent, points_sent, settings_used);
    $display("Covered band filtering, full-store contours and a %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/cemf_pkg.sv
rtl/core/cemf_ctrl.sv
rtl/core/cemf_dp.sv
rtl/core/contour_extreme_midpoint_finder.sv
tb/contour_result_checker.sv
tb/tb_contour_extreme_midpoint_finder.sv
